@@ hw/rtl/lic_pkg.sv @@
// shared types and constants for the per-cpu local interrupt controller
// no dependencies; imported by lic_regs, lic_pend and the top level
`default_nettype none

package lic_pkg;

  localparam int unsigned NUM_CPUS_DEF = 4;
  localparam int unsigned MAX_CPUS     = 4;
  localparam int unsigned MBX_WORDS    = 16;
  localparam int unsigned PEND_W       = 10;

  // word addresses of the register map
  localparam logic [5:0] W_GPU_ROUTE = 6'd3;
  localparam logic [5:0] W_PMU_SET   = 6'd4;
  localparam logic [5:0] W_PMU_CLR   = 6'd5;
  localparam logic [5:0] W_TIMER_CTL = 6'd16;
  localparam logic [5:0] W_MBOX_SET  = 6'd32;
  localparam logic [5:0] W_MBOX_CLR  = 6'd48;

  // pending word bit positions
  localparam int unsigned PB_GPU = 8;
  localparam int unsigned PB_PMU = 9;

  typedef enum logic [1:0] {
    ACT_TICK  = 2'd0,
    ACT_READ  = 2'd1,
    ACT_WRITE = 2'd2
  } lic_act_e;

  // per-cpu control groups, word address bits 3:2 inside words 16..31
  typedef enum logic [1:0] {
    GRP_TMR = 2'd0,
    GRP_MBX = 2'd1,
    GRP_IRQ = 2'd2,
    GRP_FIQ = 2'd3
  } lic_grp_e;

  typedef struct packed {
    logic [1:0]  action;
    logic [5:0]  addr;
    logic [31:0] wdata;
    logic [15:0] timer_lines;
    logic        gpu_irq_line;
    logic        gpu_fiq_line;
    logic [3:0]  pmu_lines;
  } lic_in_t;

  typedef struct packed {
    logic [31:0] rdata;
    logic        hit;
    logic [3:0]  irq_out;
    logic [3:0]  fiq_out;
  } lic_out_t;

  // post-access state as seen by the pending logic
  typedef struct packed {
    logic [MAX_CPUS-1:0][7:0] tmr_en;
    logic [MAX_CPUS-1:0][7:0] mbx_en;
    logic [MBX_WORDS-1:0]     mbx_nz;
    logic [3:0]               gpu_route;
    logic [3:0]               pmu_en;
  } lic_view_t;

  // access outcome from the register file
  typedef struct packed {
    logic        hit;
    logic [31:0] rdata;
    logic        pend_rd;
    logic        pend_fiq;
    logic [1:0]  pend_cpu;
  } lic_acc_t;

endpackage

`default_nettype wire

@@ hw/rtl/lic_regs.sv @@
// register file and address decode of the local interrupt controller
// depends on lic_pkg
`default_nettype none

module lic_regs #(
  parameter int unsigned NUM_CPUS = lic_pkg::NUM_CPUS_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             acc_en,
  input  wire lic_pkg::lic_in_t item,
  output lic_pkg::lic_view_t    view,
  output lic_pkg::lic_acc_t     acc
);
  import lic_pkg::*;

  localparam logic [MAX_CPUS-1:0] CPU_MASK = MAX_CPUS'((1 << NUM_CPUS) - 1);

  logic        is_rd, is_wr;
  logic [5:0]  a;
  logic        sel_route, sel_pmu, sel_ctl, sel_mbx, sel_any;
  lic_grp_e    grp;
  logic [1:0]  ctl_cpu;
  logic [3:0]  mbx_idx;

  logic [3:0]          route_r, route_nxt;
  logic [NUM_CPUS-1:0] pmu_en_r, pmu_en_nxt;
  logic [7:0]          tmr_q   [MAX_CPUS];
  logic [7:0]          tmr_nxt [MAX_CPUS];
  logic [7:0]          mbc_q   [MAX_CPUS];
  logic [7:0]          mbc_nxt [MAX_CPUS];
  logic [31:0]         mbx_q   [MBX_WORDS];
  logic [31:0]         mbx_nxt [MBX_WORDS];

  always_comb begin
    a         = item.addr;
    is_rd     = (item.action == ACT_READ);
    is_wr     = (item.action == ACT_WRITE);
    grp       = lic_grp_e'(a[3:2]);
    ctl_cpu   = a[1:0];
    mbx_idx   = a[3:0];
    sel_route = (a == W_GPU_ROUTE);
    sel_pmu   = (a == W_PMU_SET) || (a == W_PMU_CLR);
    sel_ctl   = (a >= W_TIMER_CTL) && (a < W_MBOX_SET) && CPU_MASK[ctl_cpu];
    sel_mbx   = (a >= W_MBOX_SET) && CPU_MASK[mbx_idx[3:2]];
    sel_any   = sel_route || sel_pmu || sel_ctl || sel_mbx;
  end

  // shared registers
  always_comb begin
    route_nxt  = route_r;
    pmu_en_nxt = pmu_en_r;
    if (is_wr && sel_route) begin
      route_nxt = item.wdata[3:0];
    end
    if (is_wr && (a == W_PMU_SET)) begin
      pmu_en_nxt = pmu_en_r | item.wdata[NUM_CPUS-1:0];
    end else if (is_wr && (a == W_PMU_CLR)) begin
      pmu_en_nxt = pmu_en_r & ~item.wdata[NUM_CPUS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      route_r  <= '0;
      pmu_en_r <= '0;
    end else if (acc_en) begin
      route_r  <= route_nxt;
      pmu_en_r <= pmu_en_nxt;
    end
  end

  // per-cpu enable bytes, stored only for present cpus
  for (genvar c = 0; c < MAX_CPUS; c++) begin : g_cpu
    if (c < NUM_CPUS) begin : g_on
      assign tmr_nxt[c] = (is_wr && sel_ctl && grp == GRP_TMR && ctl_cpu == 2'(c))
                          ? item.wdata[7:0] : tmr_q[c];
      assign mbc_nxt[c] = (is_wr && sel_ctl && grp == GRP_MBX && ctl_cpu == 2'(c))
                          ? item.wdata[7:0] : mbc_q[c];
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          tmr_q[c] <= '0;
          mbc_q[c] <= '0;
        end else if (acc_en) begin
          tmr_q[c] <= tmr_nxt[c];
          mbc_q[c] <= mbc_nxt[c];
        end
      end
    end else begin : g_off
      assign tmr_q[c]   = '0;
      assign mbc_q[c]   = '0;
      assign tmr_nxt[c] = '0;
      assign mbc_nxt[c] = '0;
    end
    assign view.tmr_en[c] = tmr_nxt[c];
    assign view.mbx_en[c] = mbc_nxt[c];
  end

  // mailboxes: set region ors in, clear region clears ones
  for (genvar w = 0; w < MBX_WORDS; w++) begin : g_mbx
    if (w / 4 < NUM_CPUS) begin : g_on
      logic wr_w;
      assign wr_w = is_wr && sel_mbx && (mbx_idx == 4'(w));
      assign mbx_nxt[w] = !wr_w ? mbx_q[w] :
                          (a >= W_MBOX_CLR) ? (mbx_q[w] & ~item.wdata)
                                            : (mbx_q[w] | item.wdata);
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          mbx_q[w] <= '0;
        end else if (acc_en) begin
          mbx_q[w] <= mbx_nxt[w];
        end
      end
    end else begin : g_off
      assign mbx_q[w]   = '0;
      assign mbx_nxt[w] = '0;
    end
    assign view.mbx_nz[w] = |mbx_nxt[w];
  end

  assign view.gpu_route = route_nxt;
  assign view.pmu_en    = 4'(pmu_en_nxt);

  // read mux; pending words are filled in by the top level
  always_comb begin
    acc.hit      = (is_rd || is_wr) && sel_any;
    acc.rdata    = '0;
    acc.pend_rd  = 1'b0;
    acc.pend_fiq = (grp == GRP_FIQ);
    acc.pend_cpu = ctl_cpu;
    if (is_rd) begin
      if (sel_route) begin
        acc.rdata = 32'(route_r);
      end else if (sel_pmu) begin
        acc.rdata = 32'(pmu_en_r);
      end else if (sel_ctl) begin
        unique case (grp)
          GRP_TMR: acc.rdata = 32'(tmr_q[ctl_cpu]);
          GRP_MBX: acc.rdata = 32'(mbc_q[ctl_cpu]);
          GRP_IRQ,
          GRP_FIQ: acc.pend_rd = 1'b1;
          default: acc.rdata = '0;
        endcase
      end else if (sel_mbx && (a >= W_MBOX_CLR)) begin
        acc.rdata = mbx_q[mbx_idx];
      end
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/lic_pend.sv @@
// per-cpu irq and fiq pending words of the local interrupt controller
// depends on lic_pkg
`default_nettype none

module lic_pend #(
  parameter int unsigned NUM_CPUS = lic_pkg::NUM_CPUS_DEF
) (
  input  wire lic_pkg::lic_view_t                              view,
  input  wire lic_pkg::lic_in_t                                item,
  output logic [lic_pkg::MAX_CPUS-1:0][lic_pkg::PEND_W-1:0]    irq_pend,
  output logic [lic_pkg::MAX_CPUS-1:0][lic_pkg::PEND_W-1:0]    fiq_pend
);
  import lic_pkg::*;

  for (genvar c = 0; c < MAX_CPUS; c++) begin : g_cpu
    if (c < NUM_CPUS) begin : g_on
      always_comb begin
        irq_pend[c] = '0;
        fiq_pend[c] = '0;
        for (int i = 0; i < 4; i++) begin
          // fiq enable wins over irq enable of the same source
          irq_pend[c][i]   = item.timer_lines[c*4+i] && view.tmr_en[c][i]
                             && !view.tmr_en[c][i+4];
          fiq_pend[c][i]   = item.timer_lines[c*4+i] && view.tmr_en[c][i+4];
          irq_pend[c][i+4] = view.mbx_nz[c*4+i] && view.mbx_en[c][i]
                             && !view.mbx_en[c][i+4];
          fiq_pend[c][i+4] = view.mbx_nz[c*4+i] && view.mbx_en[c][i+4];
        end
        irq_pend[c][PB_GPU] = item.gpu_irq_line && (view.gpu_route[1:0] == 2'(c));
        fiq_pend[c][PB_GPU] = item.gpu_fiq_line && (view.gpu_route[3:2] == 2'(c));
        irq_pend[c][PB_PMU] = item.pmu_lines[c] && view.pmu_en[c];
      end
    end else begin : g_off
      assign irq_pend[c] = '0;
      assign fiq_pend[c] = '0;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/per_cpu_local_interrupt_controller_core.sv @@
// top level of the per-cpu local interrupt controller
// depends on lic_pkg, lic_regs and lic_pend
`default_nettype none

// Register block for up to four cpus seen as 64 words: per-cpu timer and
// mailbox enable bytes (fiq enable overrides irq), gpu routing, pmu enables
// and sixteen write-to-set / write-to-clear mailboxes. Each input beat is a
// tick, a read or a write; its result beat carries the read data, the hit
// flag and the per-cpu irq/fiq levels computed after the access. An input
// beat passes the input register, then the result register, and waits in the
// input register while a stalled result blocks the way; with the output free
// a new beat is taken every cycle, and the input register still takes one
// beat while a stalled result waits. State updates commit when a beat moves
// into the result register, so beats act strictly in order. Registers of
// cpus at or above NUM_CPUS are unmapped and never raise an output.

module per_cpu_local_interrupt_controller_core #(
  parameter int unsigned NUM_CPUS = lic_pkg::NUM_CPUS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire lic_pkg::lic_in_t  in_data,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output lic_pkg::lic_out_t      out_data
);
  import lic_pkg::*;

  localparam logic [MAX_CPUS-1:0] CPU_MASK = MAX_CPUS'((1 << NUM_CPUS) - 1);

  // input register
  logic    s1_vld_r, s1_vld_nxt;
  lic_in_t s1_item_r;

  // result register
  logic     out_vld_r, out_vld_nxt;
  lic_out_t out_data_r, out_res;

  logic in_take, advance;

  lic_view_t view;
  lic_acc_t  acc;
  logic [MAX_CPUS-1:0][PEND_W-1:0] irq_pend, fiq_pend;
  logic [PEND_W-1:0] pend_sel;

  // beat moves into the result register when that slot is free or leaving
  assign advance  = s1_vld_r && (!out_vld_r || !out_stall);
  assign in_stall = s1_vld_r && !advance;
  assign in_take  = in_valid && !in_stall;

  always_comb begin
    s1_vld_nxt = s1_vld_r;
    if (in_take) begin
      s1_vld_nxt = 1'b1;
    end else if (advance) begin
      s1_vld_nxt = 1'b0;
    end
    out_vld_nxt = out_vld_r;
    if (advance) begin
      out_vld_nxt = 1'b1;
    end else if (out_vld_r && !out_stall) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      s1_vld_r  <= s1_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_item_r <= in_data;
    end
    if (advance) begin
      out_data_r <= out_res;
    end
  end

  // register file commits its update as the beat advances
  lic_regs #(
    .NUM_CPUS (NUM_CPUS)
  ) u_regs (
    .clk    (clk),
    .rst_n  (rst_n),
    .acc_en (advance),
    .item   (s1_item_r),
    .view   (view),
    .acc    (acc)
  );

  // pending words from post-access state and this beat's source levels
  lic_pend #(
    .NUM_CPUS (NUM_CPUS)
  ) u_pend (
    .view     (view),
    .item     (s1_item_r),
    .irq_pend (irq_pend),
    .fiq_pend (fiq_pend)
  );

  always_comb begin
    pend_sel = acc.pend_fiq ? fiq_pend[acc.pend_cpu] : irq_pend[acc.pend_cpu];
    out_res.rdata = acc.pend_rd ? 32'(pend_sel) : acc.rdata;
    out_res.hit   = acc.hit;
    for (int c = 0; c < MAX_CPUS; c++) begin
      out_res.irq_out[c] = |irq_pend[c];
      out_res.fiq_out[c] = |fiq_pend[c];
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_data_r;

  // absent cpus never raise an output
  a_no_absent_cpu: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> (((out_data_r.irq_out | out_data_r.fiq_out) & ~CPU_MASK) == '0))
    else $error("output raised for an absent cpu");

  // only reads return data
  a_rdata_reads_only: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && s1_item_r.action != ACT_READ) |=> (out_data_r.rdata == '0))
    else $error("nonzero read data on a tick or write");

  // a tick never hits
  a_tick_no_hit: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && s1_item_r.action != ACT_READ && s1_item_r.action != ACT_WRITE)
      |=> !out_data_r.hit)
    else $error("hit flagged on a tick");

  // input register is never overwritten while it holds a beat
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    in_take |-> (!s1_vld_r || advance))
    else $error("input register overrun");

endmodule

`default_nettype wire

@@ bench/tb_per_cpu_local_interrupt_controller_core.sv @@
// self-checking bench for per_cpu_local_interrupt_controller_core
// needs lic_pkg and the controller rtl; a built-in predictor checks each result beat
`timescale 1ns / 1ps

module tb_per_cpu_local_interrupt_controller_core;
  import lic_pkg::*;

  localparam int unsigned CPUS      = 4;
  localparam logic [3:0]  CPU_MASK  = 4'((1 << CPUS) - 1);
  localparam logic [1:0]  ACT_SPARE = 2'd3;   // undefined action, acts as a tick
  localparam logic [5:0]  W_MBOX_CTL = W_TIMER_CTL + 6'd4;
  localparam logic [5:0]  W_IRQ_PEND = W_TIMER_CTL + 6'd8;
  localparam logic [5:0]  W_FIQ_PEND = W_TIMER_CTL + 6'd12;
  localparam int          CYCLE_LIMIT = 200000;
  localparam int          N_RANDOM    = 550;

  // clock, reset and block ports; every input starts at a known value
  logic     clk       = 1'b0;
  logic     rst_n     = 1'b0;
  logic     in_valid  = 1'b0;
  logic     in_stall;
  lic_in_t  in_data   = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  lic_out_t out_data;

  // predictor copy of the register state
  logic [31:0] mbx_word [MBX_WORDS];
  logic [7:0]  tmr_en   [CPUS];
  logic [7:0]  mbx_en   [CPUS];
  logic [3:0]  gpu_route;
  logic [3:0]  pmu_en;

  lic_in_t  beat_q [$];    // input beats waiting to be driven
  lic_out_t reply_q [$];   // predicted result beats, oldest first
  lic_out_t want;

  int n_errors   = 0;
  int n_taken    = 0;
  int n_total    = 0;
  int cyc_cnt    = 0;
  int gap_left   = 0;
  int burst_left = 0;
  int stall_mode = 0;
  int mode_left  = 0;

  per_cpu_local_interrupt_controller_core #(
    .NUM_CPUS (CPUS)
  ) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  task automatic flag_error(input string msg);
    if (n_errors < 40) begin
      $display("ERROR @%0t: %s", $realtime, msg);
    end
    n_errors++;
  endtask

  // pending word of one cpu from the source levels of beat b and current state
  function automatic logic [PEND_W-1:0] pend_word(input int c, input bit fiq, input lic_in_t b);
    logic [PEND_W-1:0] p;
    bit tl, ti, tf, ml, mi, mf;
    p = '0;
    if (c >= CPUS) begin
      return '0;
    end
    for (int i = 0; i < 4; i++) begin
      tl = b.timer_lines[c*4 + i];
      ti = tmr_en[c][i];
      tf = tmr_en[c][i+4];
      ml = (mbx_word[c*4 + i] != 32'd0);
      mi = mbx_en[c][i];
      mf = mbx_en[c][i+4];
      // a set fiq enable steals the source from the irq view
      if (tl && (fiq ? tf : (ti && !tf))) p[i] = 1'b1;
      if (ml && (fiq ? mf : (mi && !mf))) p[i+4] = 1'b1;
    end
    if (fiq) begin
      if (b.gpu_fiq_line && gpu_route[3:2] == 2'(c)) p[PB_GPU] = 1'b1;
    end else begin
      if (b.gpu_irq_line && gpu_route[1:0] == 2'(c)) p[PB_GPU] = 1'b1;
      if (b.pmu_lines[c] && pmu_en[c]) p[PB_PMU] = 1'b1;
    end
    return p;
  endfunction

  // performs the access of one accepted beat and returns its result
  function automatic lic_out_t apply_beat(input lic_in_t b);
    lic_out_t r;
    logic     wr;
    int       c;
    int       idx;
    lic_grp_e grp;
    r   = '0;
    wr  = (b.action == ACT_WRITE);
    c   = b.addr[1:0];
    grp = lic_grp_e'(b.addr[3:2]);
    idx = b.addr[3:0];
    if (b.action == ACT_READ || b.action == ACT_WRITE) begin
      if (b.addr == W_GPU_ROUTE) begin
        r.hit = 1'b1;
        if (wr) gpu_route = b.wdata[3:0];
        else r.rdata = {28'd0, gpu_route};
      end else if (b.addr == W_PMU_SET || b.addr == W_PMU_CLR) begin
        r.hit = 1'b1;
        if (!wr) r.rdata = {28'd0, pmu_en};
        else if (b.addr == W_PMU_SET) pmu_en = (pmu_en | b.wdata[3:0]) & CPU_MASK;
        else pmu_en = pmu_en & ~b.wdata[3:0] & CPU_MASK;
      end else if (b.addr >= W_TIMER_CTL && b.addr < W_MBOX_SET) begin
        if (c < CPUS) begin
          r.hit = 1'b1;
          case (grp)
            GRP_TMR: begin
              if (wr) tmr_en[c] = b.wdata[7:0];
              else r.rdata = {24'd0, tmr_en[c]};
            end
            GRP_MBX: begin
              if (wr) mbx_en[c] = b.wdata[7:0];
              else r.rdata = {24'd0, mbx_en[c]};
            end
            GRP_IRQ: begin
              if (!wr) r.rdata = 32'(pend_word(c, 1'b0, b));
            end
            default: begin
              if (!wr) r.rdata = 32'(pend_word(c, 1'b1, b));
            end
          endcase
        end
      end else if (b.addr >= W_MBOX_SET) begin
        if ((idx >> 2) < CPUS) begin
          r.hit = 1'b1;
          if (b.addr < W_MBOX_CLR) begin
            if (wr) mbx_word[idx] = mbx_word[idx] | b.wdata;
          end else if (wr) begin
            mbx_word[idx] = mbx_word[idx] & ~b.wdata;
          end else begin
            r.rdata = mbx_word[idx];
          end
        end
      end
    end
    // outputs reflect the state after the access
    for (int k = 0; k < 4; k++) begin
      r.irq_out[k] = (pend_word(k, 1'b0, b) != '0);
      r.fiq_out[k] = (pend_word(k, 1'b1, b) != '0);
    end
    return r;
  endfunction

  task automatic add_beat(input logic [1:0] act, input logic [5:0] a, input logic [31:0] wd,
                          input logic [15:0] tl, input logic gi, input logic gf,
                          input logic [3:0] pl);
    lic_in_t b;
    b.action       = act;
    b.addr         = a;
    b.wdata        = wd;
    b.timer_lines  = tl;
    b.gpu_irq_line = gi;
    b.gpu_fiq_line = gf;
    b.pmu_lines    = pl;
    beat_q.push_back(b);
  endtask

  // driver: bursts of beats with random gaps; a stalled beat is held as is
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        reply_q.push_back(apply_beat(in_data));
        n_taken++;
      end
      if (in_valid && in_stall) begin
        // hold valid and payload until the block takes the beat
      end else if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (beat_q.size() > 0) begin
        in_valid <= 1'b1;
        in_data  <= beat_q.pop_front();
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          // mostly short bursts, now and then a long one with no gap at all
          burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                   : $urandom_range(0, 7);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // monitor: checks each result beat, then picks the next stall level
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (reply_q.size() == 0) begin
          flag_error($sformatf("result beat with nothing outstanding, rdata %08h",
                               out_data.rdata));
        end else begin
          want = reply_q.pop_front();
          if (out_data.rdata !== want.rdata)
            flag_error($sformatf("rdata %08h, want %08h", out_data.rdata, want.rdata));
          if (out_data.hit !== want.hit)
            flag_error($sformatf("hit %0b, want %0b", out_data.hit, want.hit));
          if (out_data.irq_out !== want.irq_out)
            flag_error($sformatf("irq_out %h, want %h", out_data.irq_out, want.irq_out));
          if (out_data.fiq_out !== want.fiq_out)
            flag_error($sformatf("fiq_out %h, want %h", out_data.fiq_out, want.fiq_out));
        end
      end
      // stall pattern switches to a new random mode when the mode counter runs out
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        mode_left  = $urandom_range(10, 80);
      end else begin
        mode_left--;
      end
      case (stall_mode)
        0:       out_stall <= 1'b0;
        1:       out_stall <= ($urandom_range(0, 2) == 0);
        2:       out_stall <= (cyc_cnt % 3 == 0);
        default: out_stall <= ($urandom_range(0, 9) < 7);
      endcase
    end
  end

  // watchdog
  always @(posedge clk) begin
    cyc_cnt++;
    if (cyc_cnt >= CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    logic [1:0]  act;
    logic [5:0]  a;
    logic [31:0] wd;
    logic [15:0] tl;
    int          n;
    for (int i = 0; i < MBX_WORDS; i++) mbx_word[i] = '0;
    for (int i = 0; i < CPUS; i++) begin
      tmr_en[i] = '0;
      mbx_en[i] = '0;
    end
    gpu_route = '0;
    pmu_en    = '0;

    // directed: reset values, each register class and the odd cases
    add_beat(ACT_READ,  W_GPU_ROUTE,        32'h0,         16'h0000, 1'b0, 1'b0, 4'h0);
    add_beat(ACT_READ,  W_PMU_SET,          32'h0,         16'h0000, 1'b0, 1'b0, 4'h0);
    add_beat(ACT_READ,  W_IRQ_PEND,         32'h0,         16'hffff, 1'b1, 1'b1, 4'hf);
    // reserved upper bits of a control byte are dropped
    add_beat(ACT_WRITE, W_TIMER_CTL,        32'hffffff0f,  16'hffff, 1'b0, 1'b0, 4'h0);
    add_beat(ACT_READ,  W_TIMER_CTL,        32'h0,         16'hffff, 1'b0, 1'b0, 4'h0);
    // fiq enable overrides irq enable on cpu1
    add_beat(ACT_WRITE, W_TIMER_CTL + 6'd1, 32'h000000ff,  16'hffff, 1'b0, 1'b0, 4'h0);
    add_beat(ACT_READ,  W_FIQ_PEND + 6'd1,  32'h0,         16'hffff, 1'b0, 1'b0, 4'h0);
    add_beat(ACT_READ,  W_IRQ_PEND + 6'd1,  32'h0,         16'hffff, 1'b0, 1'b0, 4'h0);
    // mailbox set, read back, set word reads zero, then clear
    add_beat(ACT_WRITE, W_MBOX_SET + 6'd15, 32'hffffffff,  16'h0000, 1'b0, 1'b0, 4'h0);
    add_beat(ACT_WRITE, W_MBOX_CTL + 6'd3,  32'h0000000f,  16'h0000, 1'b0, 1'b0, 4'h0);
    add_beat(ACT_READ,  W_MBOX_CLR + 6'd15, 32'h0,         16'h0000, 1'b0, 1'b0, 4'h0);
    add_beat(ACT_READ,  W_MBOX_SET + 6'd15, 32'h0,         16'h0000, 1'b0, 1'b0, 4'h0);
    add_beat(ACT_READ,  W_IRQ_PEND + 6'd3,  32'h0,         16'h0000, 1'b0, 1'b0, 4'h0);
    add_beat(ACT_WRITE, W_MBOX_CLR + 6'd15, 32'hffffffff,  16'h0000, 1'b0, 1'b0, 4'h0);
    // gpu lines steered to cpu3
    add_beat(ACT_WRITE, W_GPU_ROUTE,        32'hffffffff,  16'h0000, 1'b1, 1'b1, 4'h0);
    add_beat(ACT_TICK,  6'd0,               32'h0,         16'h0000, 1'b1, 1'b1, 4'h0);
    // pmu set and clear
    add_beat(ACT_WRITE, W_PMU_SET,          32'hffffffff,  16'h0000, 1'b0, 1'b0, 4'hf);
    add_beat(ACT_READ,  W_PMU_CLR,          32'h0,         16'h0000, 1'b0, 1'b0, 4'hf);
    add_beat(ACT_WRITE, W_PMU_CLR,          32'hfffffff5,  16'h0000, 1'b0, 1'b0, 4'hf);
    // write to a pending word has no effect but still hits
    add_beat(ACT_WRITE, W_IRQ_PEND,         32'hffffffff,  16'hffff, 1'b1, 1'b1, 4'hf);
    // unmapped words
    add_beat(ACT_READ,  6'd0,               32'h0,         16'h0000, 1'b0, 1'b0, 4'h0);
    add_beat(ACT_READ,  6'd15,              32'h0,         16'h0000, 1'b0, 1'b0, 4'h0);
    add_beat(ACT_WRITE, 6'd6,               32'hffffffff,  16'h0000, 1'b0, 1'b0, 4'h0);
    // undefined action behaves as a tick
    add_beat(ACT_SPARE, W_GPU_ROUTE,        32'hffffffff,  16'hffff, 1'b1, 1'b1, 4'hf);
    add_beat(ACT_TICK,  6'd63,              32'hffffffff,  16'h0000, 1'b0, 1'b0, 4'h0);

    // random part: mostly mapped accesses, plus post/check/clear mailbox runs
    n = 0;
    while (n < N_RANDOM) begin
      case ($urandom_range(0, 9))
        0:       a = W_GPU_ROUTE;
        1:       a = ($urandom_range(0, 1) != 0) ? W_PMU_SET : W_PMU_CLR;
        2, 3:    a = W_TIMER_CTL + 6'($urandom_range(0, 15));
        4, 5, 6: a = W_MBOX_SET + 6'($urandom_range(0, 31));
        default: a = 6'($urandom_range(0, 63));
      endcase
      case ($urandom_range(0, 5))
        0:       wd = 32'h1 << $urandom_range(0, 31);
        1:       wd = 32'hffffffff;
        2:       wd = 32'h0;
        3:       wd = 32'($urandom_range(0, 255));
        default: wd = $urandom();
      endcase
      case ($urandom_range(0, 4))
        0:       tl = 16'h0000;
        1:       tl = 16'hffff;
        default: tl = 16'($urandom());
      endcase
      case ($urandom_range(0, 19))
        0, 1, 2:     act = ACT_TICK;
        3:           act = ACT_SPARE;
        4, 5, 6, 7,
        8, 9, 10:    act = ACT_READ;
        default:     act = ACT_WRITE;
      endcase
      if ($urandom_range(0, 11) == 0) begin
        // mailbox post, observe through pending and read, then clear it
        a = W_MBOX_SET + 6'($urandom_range(0, 15));
        add_beat(ACT_WRITE, a, wd | 32'h1, tl, 1'($urandom()), 1'($urandom()),
                 4'($urandom()));
        add_beat(ACT_READ, (($urandom_range(0, 1) != 0) ? W_IRQ_PEND : W_FIQ_PEND) +
                 6'(a[3:2]), 32'($urandom()), tl, 1'($urandom()), 1'($urandom()),
                 4'($urandom()));
        add_beat(ACT_READ, a + 6'd16, 32'($urandom()), tl, 1'($urandom()),
                 1'($urandom()), 4'($urandom()));
        add_beat(ACT_WRITE, a + 6'd16, ($urandom_range(0, 2) == 0) ? $urandom()
                 : 32'hffffffff, tl, 1'($urandom()), 1'($urandom()), 4'($urandom()));
        n += 4;
      end else begin
        add_beat(act, a, wd, tl, 1'($urandom()), 1'($urandom()), 4'($urandom()));
        n++;
      end
    end
    n_total = beat_q.size();

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    while (n_taken < n_total) @(posedge clk);
    while (reply_q.size() != 0) @(posedge clk);
    // two-stage pipe: an extra wait after the last reply catches any stray result beat
    repeat (10) @(posedge clk);
    if (n_errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
